>>> design/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, constants and helpers for the four-bone skinning unit.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int DEF_BONES  = 128;
  localparam int INFLUENCES = 4;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = 32;

  localparam logic [15:0] WEIGHT_ONE = 16'd32768;
  localparam logic signed [31:0] FIX_ONE = 32'sd65536;

  typedef enum logic [1:0] {
    FN_POSE = 2'd0,
    FN_INVB = 2'd1,
    FN_INFL = 2'd2,
    FN_SKIN = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_WMUL, S_WACC, S_TMUL, S_TACC,
    S_QMUL, S_QACC, S_SQRT, S_DSTART, S_DWAIT, S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic signed [32:0] e;
    e = 33'(x);
    if (e < 0) e = -e;
    return e[31:0];
  endfunction

endpackage

>>> design/lbvs_div.sv
// ----------------------------------------------------------------------------
// lbvs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbvs_div import lbvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;

  assign trial = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= DEN_W'(trial - {1'b0, den});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == CW'(NUM_W)) else $error("divider did not start");
  a_end: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == CW'(1)) |=> !busy) else $error("divider overran");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy) else $error("divider woke without start");

endmodule

>>> design/linear_blend_vertex_skinning_top.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Four-bone linear blend skinning, Q16.16 positions and Q2.16 normals, on one shared multiplier.
//
//   channel | signals                                    | direction
//   in      | in_valid/in_stall, func..nrm_z              | to block
//   out     | out_valid/out_stall, out_pos_x..normal_zero | from block
//
// Palette writes and influence sets are accepted only while idle.
// A vertex result is computed in order: the blended skin matrix (256 palette
// products, then 64 weight products), the transform and squares, the square
// root, six 48-bit serial divides, and finally the result state.
// Reset clears the influences and control; palettes hold no reset value.
// in_stall is high from vertex transfer until its result transfers.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_top import lbvs_pkg::*; #(
  parameter int BONES = DEF_BONES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         bone,
  input  logic [3:0]         element,
  input  logic signed [31:0] value,
  input  logic [1:0]         influence_slot,
  input  logic [15:0]        weight,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] nrm_x,
  input  logic signed [31:0] nrm_y,
  input  logic signed [31:0] nrm_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [17:0] out_nrm_x,
  output logic signed [17:0] out_nrm_y,
  output logic signed [17:0] out_nrm_z,
  output logic               w_zero,
  output logic               normal_zero
);

  localparam int DEPTH = BONES * 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  logic signed [31:0] pose_mem [DEPTH];
  logic signed [31:0] inv_mem  [DEPTH];
  logic signed [31:0] pose_rd, inv_rd;

  logic [6:0]  infl_bone   [INFLUENCES];
  logic [15:0] infl_weight [INFLUENCES];

  logic signed [31:0] vx, vy, vz, nx, ny, nz;
  logic signed [31:0] skin [16];
  logic signed [31:0] tv [7];
  logic signed [31:0] bm;

  logic [3:0] e;
  logic [1:0] i, k, c;
  logic [2:0] j, d;

  logic signed [49:0] acc, acc_sum, sacc, sacc_sum;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b, vec, tsel;
  logic [2:0]  tidx;
  logic [63:0] sq_s, sq_r, sq_bit, sq_sum, sq_rb;

  logic            accept, last_c, bone_ok, rd_ok;
  logic [AW-1:0]   wr_addr, pose_addr, inv_addr;
  logic [6:0]      rd_bone;

  logic             div_start, div_busy, div_neg;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;
  logic signed [NUM_W:0] qs;

  logic w_zero_r, nz_r;

  assign accept  = in_valid && !in_stall;
  assign bone_ok = 32'(bone) < BONES;
  assign wr_addr = AW'(32'(bone) * 16 + 32'(element));

  assign rd_bone   = infl_bone[i];
  assign rd_ok     = 32'(rd_bone) < BONES;
  assign pose_addr = AW'(32'(rd_bone) * 16 + 32'({e[3:2], k}));
  assign inv_addr  = AW'(32'(rd_bone) * 16 + 32'({k, e[1:0]}));

  always_ff @(posedge clk) begin
    if (accept && func == FN_POSE && bone_ok) pose_mem[wr_addr] <= value;
    if (accept && func == FN_INVB && bone_ok) inv_mem[wr_addr]  <= value;
    pose_rd <= pose_mem[pose_addr];
    inv_rd  <= inv_mem[inv_addr];
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (c)
      2'd0: vec = j[2] ? nx : vx;
      2'd1: vec = j[2] ? ny : vy;
      2'd2: vec = j[2] ? nz : vz;
      default: vec = FIX_ONE;
    endcase
    if (state == S_QMUL) tidx = 3'(4 + 32'(c));
    else if (d < 3'd3) tidx = d;
    else tidx = d + 3'd1;
    tsel = tv[tidx];
    case (state)
      S_MUL: begin
        mul_a = rd_ok ? pose_rd : '0;
        mul_b = rd_ok ? inv_rd : '0;
      end
      S_WMUL: begin
        mul_a = bm;
        mul_b = signed'({16'd0, infl_weight[i]});
      end
      S_TMUL: begin
        mul_a = skin[{j[1:0], c}];
        mul_b = vec;
      end
      S_QMUL: begin
        mul_a = tsel;
        mul_b = tsel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum  = acc + 50'(prod >>> 16);
  assign sacc_sum = sacc + 50'(prod);
  assign sq_sum   = sq_s + unsigned'(prod);
  assign sq_rb    = sq_r + sq_bit;
  assign last_c   = j[2] ? (c == 2'd2) : (c == 2'd3);

  // divider operands
  always_comb begin
    div_num = {abs32(tsel), 16'd0};
    if (d < 3'd3) begin
      div_den = (w_zero_r) ? DEN_W'(1) : abs32(tv[3]);
      div_neg = tsel[31] ^ tv[3][31];
    end else begin
      div_den = (nz_r) ? DEN_W'(1) : sq_r[DEN_W-1:0];
      div_neg = tsel[31];
    end
    qs = div_neg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
  end

  assign div_start = (state == S_DSTART);

  lbvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept && func == FN_SKIN) state_next = S_RD;
      S_RD:     state_next = S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (k == 2'd3) ? S_WMUL : S_RD;
      S_WMUL:   state_next = S_WACC;
      S_WACC:   state_next = (i == 2'd3 && e == 4'd15) ? S_TMUL : S_RD;
      S_TMUL:   state_next = S_TACC;
      S_TACC:   state_next = (last_c && j == 3'd6) ? S_QMUL : S_TMUL;
      S_QMUL:   state_next = S_QACC;
      S_QACC:   state_next = (c == 2'd2) ? S_SQRT : S_QMUL;
      S_SQRT:   if (sq_bit[0]) state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (!div_busy) state_next = (d == 3'd5) ? S_OUT : S_DSTART;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign w_zero      = w_zero_r;
  assign normal_zero = nz_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < INFLUENCES; n++) begin
        infl_bone[n]   <= '0;
        infl_weight[n] <= '0;
      end
      e <= '0; i <= '0; k <= '0; c <= '0; j <= '0; d <= '0;
      w_zero_r <= 1'b0;
      nz_r     <= 1'b0;
    end else begin
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (accept && func == FN_INFL) begin
            infl_bone[influence_slot]   <= bone;
            infl_weight[influence_slot] <= (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
          end
          if (accept && func == FN_SKIN) begin
            vx <= pos_x; vy <= pos_y; vz <= pos_z;
            nx <= nrm_x; ny <= nrm_y; nz <= nrm_z;
            e <= '0; i <= '0; k <= '0;
            acc <= '0; sacc <= '0;
          end
        end
        S_ACC: begin
          if (k == 2'd3) begin
            bm  <= sat32(64'(acc_sum));
            acc <= '0;
            k   <= '0;
          end else begin
            acc <= acc_sum;
            k   <= k + 2'd1;
          end
        end
        S_WACC: begin
          if (i == 2'd3) begin
            skin[e] <= sat32(64'(sacc_sum >>> 15));
            sacc <= '0;
            i    <= '0;
            e    <= e + 4'd1;
            j    <= '0;
            c    <= '0;
          end else begin
            sacc <= sacc_sum;
            i    <= i + 2'd1;
          end
        end
        S_TACC: begin
          if (last_c) begin
            tv[j] <= sat32(64'(acc_sum));
            acc   <= '0;
            c     <= '0;
            j     <= j + 3'd1;
            sq_s  <= '0;
          end else begin
            acc <= acc_sum;
            c   <= c + 2'd1;
          end
        end
        S_QACC: begin
          sq_s <= sq_sum;
          if (c == 2'd2) begin
            nz_r     <= (sq_sum == 64'd0);
            w_zero_r <= (tv[3] == 32'sd0);
            sq_r     <= '0;
            sq_bit   <= 64'd1 << 62;
            d        <= '0;
          end else begin
            c <= c + 2'd1;
          end
        end
        S_SQRT: begin
          if (sq_s >= sq_rb) begin
            sq_s <= sq_s - sq_rb;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        S_DWAIT: begin
          if (!div_busy) begin
            case (d)
              3'd0: out_pos_x <= w_zero_r ? '0 : sat32(64'(qs));
              3'd1: out_pos_y <= w_zero_r ? '0 : sat32(64'(qs));
              3'd2: out_pos_z <= w_zero_r ? '0 : sat32(64'(qs));
              3'd3: out_nrm_x <= nz_r ? '0 : qs[17:0];
              3'd4: out_nrm_y <= nz_r ? '0 : qs[17:0];
              default: out_nrm_z <= nz_r ? '0 : qs[17:0];
            endcase
            d <= d + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_wz: assert property (@(posedge clk) disable iff (rst)
    (out_valid && w_zero) |-> (out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0))
    else $error("w zero with nonzero position");
  a_nz: assert property (@(posedge clk) disable iff (rst)
    (out_valid && normal_zero) |-> (out_nrm_x == 0 && out_nrm_y == 0 && out_nrm_z == 0))
    else $error("zero normal with nonzero output");
  a_nrange: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_nrm_x >= -18'sd65536 && out_nrm_x <= 18'sd65536 &&
                   out_nrm_y >= -18'sd65536 && out_nrm_y <= 18'sd65536))
    else $error("normal out of unit range");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DWAIT) else $error("divider busy outside divide");

endmodule
